FILE: design/assert_macros.svh
// assertion macros shared by the steering controller rtl
// every macro expects a clock named clk and an active-high reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lps_pkg.sv
// shared types, constants and constant dividers for the steering controller
// used by lps_terms and line_position_pid_steering; no dependencies
package lps_pkg;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2
  } cfg_reg_t;

  localparam logic [2:0]         MAX_INDEX   = 3'd6;
  localparam logic signed [12:0] CENTER_POS  = 13'sd1536;
  localparam logic signed [9:0]  CORR_MAX    = 10'sd305;
  localparam logic signed [9:0]  CORR_MIN    = -10'sd305;
  localparam logic signed [15:0] INTEG_MAX   = 16'sd20000;
  localparam logic signed [15:0] INTEG_MIN   = -16'sd20000;
  localparam logic signed [11:0] SERVO_MID   = 12'sd1500;

  // reciprocal constants, exact for the magnitudes seen here
  localparam logic [20:0] DIV10_MUL    = 21'd1677722;
  localparam int          DIV10_SHIFT  = 24;
  localparam logic [20:0] DIV100_MUL   = 21'd1342178;
  localparam int          DIV100_SHIFT = 27;
  localparam logic [23:0] DIV1000_MUL  = 24'd8589935;
  localparam int          DIV1000_SHIFT = 33;

  // feed-forward part of one item, ready for the integral loop
  typedef struct packed {
    logic signed [16:0] corr_ff;     // p term + d term
    logic signed [8:0]  integ_step;  // error / 10
    logic signed [27:0] hi_pos;      // upper limit compare, product >= 0
    logic signed [27:0] hi_neg;      // upper limit compare, product < 0
    logic signed [27:0] lo_pos;      // lower limit compare, product >= 0
    logic signed [27:0] lo_neg;      // lower limit compare, product < 0
  } lps_terms_t;

  // truncating division toward zero by ten
  function automatic logic signed [19:0] sdiv10(input logic signed [19:0] x);
    logic [19:0] mag;
    logic [40:0] prod;
    logic [19:0] quo;
    mag  = x[19] ? 20'(-x) : 20'(x);
    prod = {21'b0, mag} * {20'b0, DIV10_MUL};
    quo  = 20'(prod >> DIV10_SHIFT);
    return x[19] ? -$signed(quo) : $signed(quo);
  endfunction

  // truncating division toward zero by one hundred
  function automatic logic signed [20:0] sdiv100(input logic signed [20:0] x);
    logic [20:0] mag;
    logic [41:0] prod;
    logic [20:0] quo;
    mag  = x[20] ? 21'(-x) : 21'(x);
    prod = {21'b0, mag} * {21'b0, DIV100_MUL};
    quo  = 21'(prod >> DIV100_SHIFT);
    return x[20] ? -$signed(quo) : $signed(quo);
  endfunction

  // truncating division toward zero by one thousand
  function automatic logic signed [23:0] sdiv1000(input logic signed [23:0] x);
    logic [23:0] mag;
    logic [47:0] prod;
    logic [23:0] quo;
    mag  = x[23] ? 24'(-x) : 24'(x);
    prod = {24'b0, mag} * {24'b0, DIV1000_MUL};
    quo  = 24'(prod >> DIV1000_SHIFT);
    return x[23] ? -$signed(quo) : $signed(quo);
  endfunction

endpackage

FILE: design/line_position_pid_steering.sv
// Line-position PID steering controller. One sensor transfer in gives one
// servo transfer out; a new item is taken every cycle unless the output
// side stalls. An item passes the four lps_terms stages, the integral loop
// register and the output register. The rate is set by the integral loop
// stage: one 8x16 multiply of the integral gain with the running integral
// and a compare against limits prepared earlier in the pipeline. Gains are
// written through cfg_we / cfg_index / cfg_data by the user only while no
// item is in flight; the block does not enforce this. Index 3 is ignored.
// Depends on lps_pkg, lps_terms and assert_macros.svh.
`include "assert_macros.svh"

module line_position_pid_steering (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // peak_index[2:0], left_level[10:3], right_level[18:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // servo_pulse[10:0]
  output logic        m_tuser,   // clamped[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lps_pkg::*;

  logic [7:0]         prop_gain;
  logic [7:0]         integ_gain;
  logic [7:0]         deriv_gain;

  logic signed [15:0] integ_sum;
  logic signed [15:0] integ_sum_next;

  logic               terms_valid;
  logic               terms_ready;
  lps_terms_t         terms;

  logic               v5;
  logic               r5;
  logic               r6;
  logic               loop_take;
  logic signed [23:0] t5;
  logic signed [16:0] a5;
  logic               sat_hi5;
  logic               sat_lo5;

  logic signed [24:0] tprod_full;
  logic signed [23:0] tprod;
  logic signed [27:0] tprod_ext;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [16:0] sum_full;

  logic signed [24:0] corr_sum;
  logic signed [9:0]  corr;
  logic signed [11:0] servo_full;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  lps_terms u_terms (
    .clk         (clk),
    .rst         (rst),
    .prop_gain   (prop_gain),
    .deriv_gain  (deriv_gain),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .peak_index  (s_tdata[2:0]),
    .left_level  (s_tdata[10:3]),
    .right_level (s_tdata[18:11]),
    .out_valid   (terms_valid),
    .out_ready   (terms_ready),
    .terms       (terms)
  );

  assign r6          = !m_tvalid || m_tready;
  assign r5          = !v5 || r6;
  assign terms_ready = r5;
  assign loop_take   = terms_valid && r5;

  // integral loop: saturation decided on ki*integral against the limits
  always_comb begin
    tprod_full = $signed({1'b0, integ_gain}) * integ_sum;
    tprod      = tprod_full[23:0];
    tprod_ext  = 28'(tprod);
    sat_hi     = tprod[23] ? (tprod_ext >= terms.hi_neg) : (tprod_ext >= terms.hi_pos);
    sat_lo     = tprod[23] ? (tprod_ext <= terms.lo_neg) : (tprod_ext <= terms.lo_pos);
    sum_full   = integ_sum + terms.integ_step;
    priority if (sum_full > INTEG_MAX) begin
      integ_sum_next = INTEG_MAX;
    end else if (sum_full < INTEG_MIN) begin
      integ_sum_next = INTEG_MIN;
    end else begin
      integ_sum_next = sum_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum <= '0;
    end else if (loop_take && !sat_hi && !sat_lo) begin
      integ_sum <= integ_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      t5      <= tprod;
      a5      <= terms.corr_ff;
      sat_hi5 <= sat_hi;
      sat_lo5 <= sat_lo;
    end
  end

  // output stage: final correction and servo pulse
  always_comb begin
    corr_sum = a5 + sdiv1000(t5);
    priority if (sat_hi5) begin
      corr = CORR_MAX;
    end else if (sat_lo5) begin
      corr = CORR_MIN;
    end else begin
      corr = corr_sum[9:0];
    end
    servo_full = SERVO_MID - corr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (r6) begin
      m_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r6) begin
      m_tdata <= {5'b0, servo_full[10:0]};
      m_tuser <= sat_hi5 || sat_lo5;
    end
  end

  `ASSERT_ALWAYS(a_integ_range,
    (integ_sum <= INTEG_MAX) && (integ_sum >= INTEG_MIN),
    "integral out of range")
  `ASSERT_IMPL(a_clamp_pulse, m_tvalid && m_tuser,
    (m_tdata[10:0] == 11'd1195) || (m_tdata[10:0] == 11'd1805),
    "clamped pulse not at a limit")
  `ASSERT_IMPL(a_free_pulse, m_tvalid && !m_tuser,
    (m_tdata[10:0] > 11'd1195) && (m_tdata[10:0] < 11'd1805),
    "unclamped pulse at or past a limit")
  `ASSERT_NEXT(a_integ_hold, !loop_take, $stable(integ_sum),
    "integral moved without a loop transfer")

endmodule

FILE: design/lps_terms.sv
// feed-forward pipeline: error, derivative, p and d terms, integral step
// and the saturation thresholds; depends on lps_pkg
module lps_terms (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              prop_gain,
  input  logic [7:0]              deriv_gain,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              peak_index,
  input  logic [7:0]              left_level,
  input  logic [7:0]              right_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lps_pkg::lps_terms_t     terms
);
  import lps_pkg::*;

  logic signed [11:0] last_error;

  logic               v1, v2, v3;
  logic               r1, r2, r3, r4;
  logic signed [11:0] err1;
  logic signed [12:0] dif1;
  logic signed [19:0] pe2;
  logic signed [20:0] pd2;
  logic signed [8:0]  q2, q3;
  logic signed [16:0] a3;

  logic [2:0]         idx_sat;
  logic signed [12:0] pos;
  logic signed [12:0] err_full;
  logic signed [11:0] err_new;
  logic signed [12:0] err_ext;
  logic signed [12:0] last_ext;
  logic signed [12:0] dif_full;
  logic signed [20:0] pe_full;
  logic signed [21:0] pd_full;
  logic signed [19:0] err1_ext;
  logic signed [19:0] q_full;
  logic signed [21:0] a_full;
  logic signed [27:0] a_wide;
  logic signed [27:0] k_hi;
  logic signed [27:0] k_lo;
  logic signed [27:0] hi_pos_c;
  logic signed [27:0] lo_neg_c;

  // each stage takes a new item when empty or when its item moves on
  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // stage 1: position error and its change since the last item
  always_comb begin
    idx_sat  = (peak_index > MAX_INDEX) ? MAX_INDEX : peak_index;
    pos      = $signed({1'b0, idx_sat, 9'b0}) + $signed({5'b0, right_level})
             - $signed({5'b0, left_level});
    err_full = CENTER_POS - pos;
    err_new  = err_full[11:0];
    err_ext  = 13'(err_new);
    last_ext = 13'(last_error);
    dif_full = err_ext - last_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (in_valid && in_ready) begin
      last_error <= err_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      err1 <= err_new;
      dif1 <= dif_full;
    end
  end

  // stage 2: gain products and the integral step
  always_comb begin
    pe_full  = $signed({1'b0, prop_gain}) * err1;
    pd_full  = $signed({1'b0, deriv_gain}) * dif1;
    err1_ext = 20'(err1);
    q_full   = sdiv10(err1_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      pe2 <= pe_full[19:0];
      pd2 <= pd_full[20:0];
      q2  <= q_full[8:0];
    end
  end

  // stage 3: scale p and d terms down and add them
  assign a_full = sdiv10(pe2) + sdiv100(pd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      a3 <= a_full[16:0];
      q3 <= q2;
    end
  end

  // stage 4: limits on ki*integral that make the correction reach +-305,
  // with the truncation of the /1000 folded in per sign
  always_comb begin
    a_wide   = 28'(a3);
    k_hi     = 28'(CORR_MAX) - a_wide;
    k_lo     = 28'(CORR_MIN) - a_wide;
    hi_pos_c = k_hi * 28'sd1000;
    lo_neg_c = k_lo * 28'sd1000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      terms.corr_ff    <= a3;
      terms.integ_step <= q3;
      terms.hi_pos     <= hi_pos_c;
      terms.hi_neg     <= hi_pos_c - 28'sd999;
      terms.lo_pos     <= lo_neg_c + 28'sd999;
      terms.lo_neg     <= lo_neg_c;
    end
  end

endmodule
